/* hdl/switch_mode_controller_top_macros.svh */
`ifndef SWITCH_MODE_CONTROLLER_TOP_MACROS_SVH
`define SWITCH_MODE_CONTROLLER_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SMC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("switch mode controller check failed");

// condition that must hold in the cycle after a trigger
`define SMC_ASSERT_NEXT(label, trig, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (post)) \
        else $error("switch mode controller sequence check failed");

`endif

/* hdl/smc_pkg.sv */
`default_nettype none

package smc_pkg;

    // register file geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_LONG_PRESS    = 3'd0;
    localparam logic [2:0] REG_TOP_LIMIT     = 3'd1;
    localparam logic [2:0] REG_LOW_THRESH    = 3'd2;
    localparam logic [2:0] REG_CRIT_THRESH   = 3'd3;
    localparam logic [2:0] REG_LOWBATT_DELAY = 3'd4;
    localparam logic [2:0] REG_GREEN_THRESH  = 3'd5;
    localparam logic [2:0] REG_YELLOW_THRESH = 3'd6;
    localparam logic [2:0] REG_STEP_DIR      = 3'd7;

    // fixed constants
    localparam logic [3:0] DEBOUNCE_MASK = 4'b1111;
    localparam logic [7:0] ADC_FULL_42   = 8'd185;
    localparam logic [7:0] VOLT_FOUR     = 8'd169;
    localparam logic [6:0] MIN_LONG      = 7'd2;
    localparam logic [7:0] LEVEL_TOP     = 8'd255;

    typedef struct packed {
        logic [6:0]  long_press_ticks;
        logic [15:0] top_limit;
        logic [7:0]  low_threshold;
        logic [7:0]  critical_threshold;
        logic [7:0]  lowbatt_delay;
        logic [7:0]  green_threshold;
        logic [7:0]  yellow_threshold;
        logic        short_steps_up;
    } cfg_t;

    typedef struct packed {
        logic [3:0]       switch_history;
        logic [7:0]       hold_count;
        logic [7:0]       on_time;
        logic [15:0]      top_mode_ticks;
        logic [7:0]       low_count;
        logic [3:0][7:0]  sample_window;
        logic [2:0]       current_mode;
        logic             readout_armed;
        logic [1:0]       lamp_colors;
    } state_t;

    typedef struct packed {
        logic       switch_down;
        logic       sample_ready;
        logic [7:0] battery_sample;
    } item_t;

    typedef struct packed {
        logic [2:0] mode_number;
        logic [7:0] drive_level;
        logic       fast_pwm;
        logic       green_on;
        logic       red_on;
        logic [2:0] blink_count;
        logic       blink_request;
    } result_t;

    localparam cfg_t CFG_RESET = '{
        long_press_ticks:   7'd21,
        top_limit:          16'd5625,
        low_threshold:      8'd123,
        critical_threshold: 8'd113,
        lowbatt_delay:      8'd188,
        green_threshold:    8'd154,
        yellow_threshold:   8'd139,
        short_steps_up:     1'b0
    };

    localparam state_t STATE_RESET = '{
        switch_history: 4'd0,
        hold_count:     8'd0,
        on_time:        8'd0,
        top_mode_ticks: 16'd0,
        low_count:      8'd0,
        sample_window:  {4{VOLT_FOUR}},
        current_mode:   3'd0,
        readout_armed:  1'b0,
        lamp_colors:    2'd0
    };

    // drive level per mode, modes past the table are dark
    function automatic logic [7:0] level_of(input logic [2:0] mode);
        logic [7:0] lvl;
        case (mode)
            3'd1:    lvl = 8'd1;
            3'd2:    lvl = 8'd3;
            3'd3:    lvl = 8'd12;
            3'd4:    lvl = 8'd40;
            3'd5:    lvl = 8'd125;
            3'd6:    lvl = 8'd255;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

    // fast pwm flag per mode
    function automatic logic fast_of(input logic [2:0] mode);
        logic f;
        case (mode)
            3'd3, 3'd4, 3'd5: f = 1'b1;
            default:          f = 1'b0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* hdl/smc_in_if.sv */
`default_nettype none

interface smc_in_if;
    logic       valid;
    logic       ready;
    logic       switch_down;
    logic       sample_ready;
    logic [7:0] battery_sample;

    modport source (output valid, switch_down, sample_ready, battery_sample, input ready);
    modport sink   (input valid, switch_down, sample_ready, battery_sample, output ready);
endinterface

`default_nettype wire

/* hdl/smc_out_if.sv */
`default_nettype none

interface smc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode_number;
    logic [7:0] drive_level;
    logic       fast_pwm;
    logic       green_on;
    logic       red_on;
    logic [2:0] blink_count;
    logic       blink_request;

    modport source (output valid, mode_number, drive_level, fast_pwm, green_on, red_on,
                    blink_count, blink_request, input ready);
    modport sink   (input valid, mode_number, drive_level, fast_pwm, green_on, red_on,
                    blink_count, blink_request, output ready);
endinterface

`default_nettype wire

/* hdl/switch_mode_controller_top.sv */
// an accepted input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while results are taken, set by the single state update
// from input to result register; a waiting result lets input in until both registers are full
// reset: asynchronous, active low; state and valid flags reset at once, data registers do not
`default_nettype none

`include "switch_mode_controller_top_macros.svh"

module switch_mode_controller_top #(
    parameter int MODE_COUNT = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [smc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smc_pkg::DATA_W-1:0] pwdata,
    output logic      [smc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    smc_in_if.sink                          in_ch,
    smc_out_if.source                       out_ch
);
    import smc_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    smc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smc_step #(
        .MODE_COUNT (MODE_COUNT)
    ) u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // handshake between input register and result register
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= '{switch_down:    in_ch.switch_down,
                        sample_ready:   in_ch.sample_ready,
                        battery_sample: in_ch.battery_sample};
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= advance || (out_valid_reg && !out_ch.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.mode_number   = res_reg.mode_number;
    assign out_ch.drive_level   = res_reg.drive_level;
    assign out_ch.fast_pwm      = res_reg.fast_pwm;
    assign out_ch.green_on      = res_reg.green_on;
    assign out_ch.red_on        = res_reg.red_on;
    assign out_ch.blink_count   = res_reg.blink_count;
    assign out_ch.blink_request = res_reg.blink_request;

    // checks
    `SMC_ASSERT_ALWAYS(mode_in_range, {1'b0, state_reg.current_mode} < 4'(MODE_COUNT))
    `SMC_ASSERT_ALWAYS(blinks_need_request,
        !out_valid_reg || res_reg.blink_request || res_reg.blink_count == 3'd0)
    `SMC_ASSERT_ALWAYS(off_is_dark,
        !out_valid_reg || res_reg.mode_number != 3'd0 || res_reg.drive_level == 8'd0)
    `SMC_ASSERT_NEXT(stalled_item_kept, in_valid_reg && out_valid_reg && !out_ch.ready,
        in_valid_reg && $stable(in_reg) && $stable(state_reg))

endmodule

`default_nettype wire

/* hdl/smc_regs.sv */
`default_nettype none

module smc_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [smc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [smc_pkg::DATA_W-1:0] pwdata,
    output logic      [smc_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output smc_pkg::cfg_t                  cfg
);
    import smc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       write_en;

    assign index    = paddr[4:2];
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (index)
                REG_LONG_PRESS:    cfg_next.long_press_ticks   = pwdata[6:0];
                REG_TOP_LIMIT:     cfg_next.top_limit          = pwdata[15:0];
                REG_LOW_THRESH:    cfg_next.low_threshold      = pwdata[7:0];
                REG_CRIT_THRESH:   cfg_next.critical_threshold = pwdata[7:0];
                REG_LOWBATT_DELAY: cfg_next.lowbatt_delay      = pwdata[7:0];
                REG_GREEN_THRESH:  cfg_next.green_threshold    = pwdata[7:0];
                REG_YELLOW_THRESH: cfg_next.yellow_threshold   = pwdata[7:0];
                REG_STEP_DIR:      cfg_next.short_steps_up     = pwdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (index)
            REG_LONG_PRESS:    prdata = {25'd0, cfg_reg.long_press_ticks};
            REG_TOP_LIMIT:     prdata = {16'd0, cfg_reg.top_limit};
            REG_LOW_THRESH:    prdata = {24'd0, cfg_reg.low_threshold};
            REG_CRIT_THRESH:   prdata = {24'd0, cfg_reg.critical_threshold};
            REG_LOWBATT_DELAY: prdata = {24'd0, cfg_reg.lowbatt_delay};
            REG_GREEN_THRESH:  prdata = {24'd0, cfg_reg.green_threshold};
            REG_YELLOW_THRESH: prdata = {24'd0, cfg_reg.yellow_threshold};
            REG_STEP_DIR:      prdata = {31'd0, cfg_reg.short_steps_up};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/smc_step.sv */
`default_nettype none

module smc_step #(
    parameter int MODE_COUNT = 7
) (
    input  wire smc_pkg::cfg_t    cfg,
    input  wire smc_pkg::state_t  state,
    input  wire smc_pkg::item_t   item,
    output smc_pkg::state_t       state_next,
    output smc_pkg::result_t      result
);
    import smc_pkg::*;

    localparam logic [3:0] MODE_LIMIT = 4'(MODE_COUNT);
    localparam logic [2:0] MODE_LAST  = 3'(MODE_COUNT - 1);

    function automatic logic [2:0] mode_up(input logic [2:0] m);
        logic [3:0] n;
        n = {1'b0, m} + 4'd1;
        return (n >= MODE_LIMIT) ? 3'd0 : n[2:0];
    endfunction

    function automatic logic [2:0] mode_down(input logic [2:0] m);
        return (m == 3'd0) ? MODE_LAST : m - 3'd1;
    endfunction

    logic [6:0] lp;
    logic [7:0] lp2;
    logic [7:0] hold_inc;
    logic       pressed;
    logic       short_release;
    logic [3:0] history;
    logic [7:0] on0;
    logic [2:0] mode_a;
    logic [2:0] mode_b;
    logic [15:0] top_inc;
    logic [3:0][7:0] window;
    logic [9:0] sum;
    logic [7:0] avg;
    logic [7:0] thr;
    logic [7:0] low_n;
    logic [2:0] blinks;
    logic       request;

    // effective long period and debounced switch
    assign lp       = (cfg.long_press_ticks < MIN_LONG) ? MIN_LONG : cfg.long_press_ticks;
    assign lp2      = {lp, 1'b0};
    assign history  = {state.switch_history[2:0], item.switch_down};
    assign pressed  = (history & DEBOUNCE_MASK) != 4'd0;
    assign hold_inc = (state.hold_count == 8'hFF) ? 8'hFF : state.hold_count + 8'd1;
    assign on0      = (state.current_mode == 3'd0) ? 8'd0 :
                      ((state.on_time == 8'hFF) ? 8'hFF : state.on_time + 8'd1);
    assign short_release = (state.hold_count != 8'd0) && (state.hold_count < {1'b0, lp});
    assign top_inc  = (state.top_mode_ticks == 16'hFFFF) ? 16'hFFFF
                                                         : state.top_mode_ticks + 16'd1;

    // battery window and average
    assign window = {item.battery_sample, state.sample_window[3:1]};
    assign sum    = {2'b0, window[0]} + {2'b0, window[1]} + {2'b0, window[2]}
                  + {2'b0, window[3]};
    assign avg    = sum[9:2];

    // one tick of the controller
    always_comb
    begin
        state_next = state;
        state_next.switch_history = history;
        state_next.on_time = on0;
        mode_a  = state.current_mode;
        mode_b  = state.current_mode;
        thr     = cfg.low_threshold;
        low_n   = state.low_count;
        blinks  = 3'd0;
        request = 1'b0;

        if (pressed)
        begin
            state_next.hold_count = hold_inc;
            if (hold_inc == lp2 - 8'd1 || hold_inc == {1'b0, lp} - 8'd1)
            begin
                mode_b = cfg.short_steps_up ? mode_down(state.current_mode)
                                            : mode_up(state.current_mode);
            end
            if (hold_inc == lp2)
            begin
                state_next.hold_count = {1'b0, lp};
            end
            state_next.top_mode_ticks = 16'd0;
            state_next.low_count = 8'd0;
        end
        else
        begin
            state_next.hold_count = 8'd0;
            if (short_release)
            begin
                mode_b = cfg.short_steps_up ? mode_up(state.current_mode)
                                            : mode_down(state.current_mode);
                if ({1'b0, on0} < {1'b0, lp2})
                begin
                    state_next.on_time = 8'd1;
                    if (mode_b == 3'd0)
                    begin
                        state_next.readout_armed = 1'b1;
                    end
                end
            end
            else
            begin
                // turbo fall back
                if (level_of(state.current_mode) == LEVEL_TOP)
                begin
                    state_next.top_mode_ticks = top_inc;
                    if (top_inc > cfg.top_limit)
                    begin
                        mode_a = mode_down(state.current_mode);
                    end
                end
                // new battery sample
                if (item.sample_ready)
                begin
                    state_next.sample_window = window;
                    thr = (mode_a == 3'd1) ? cfg.critical_threshold : cfg.low_threshold;
                    if (avg < thr)
                    begin
                        low_n = (state.low_count == 8'hFF) ? 8'hFF : state.low_count + 8'd1;
                    end
                    else
                    begin
                        low_n = 8'd0;
                    end
                    if (avg > cfg.green_threshold)
                    begin
                        state_next.lamp_colors = 2'b01;
                    end
                    else if (avg > cfg.yellow_threshold)
                    begin
                        state_next.lamp_colors = 2'b11;
                    end
                    else
                    begin
                        state_next.lamp_colors = 2'b10;
                    end
                    if (state.readout_armed)
                    begin
                        if (avg >= ADC_FULL_42)
                            blinks = 3'd5;
                        else if (avg > VOLT_FOUR)
                            blinks = 3'd4;
                        else if (avg > cfg.green_threshold)
                            blinks = 3'd3;
                        else if (avg > cfg.yellow_threshold)
                            blinks = 3'd2;
                        else if (avg > cfg.low_threshold)
                            blinks = 3'd1;
                        else
                            blinks = 3'd0;
                        request = 1'b1;
                        state_next.readout_armed = 1'b0;
                    end
                end
                // low battery step down
                mode_b = mode_a;
                if (low_n >= cfg.lowbatt_delay)
                begin
                    mode_b = mode_down(mode_a);
                    low_n  = 8'd0;
                end
                state_next.low_count = low_n;
            end
        end
        state_next.current_mode = mode_b;
    end

    // result beat
    assign result.mode_number   = state_next.current_mode;
    assign result.drive_level   = level_of(state_next.current_mode);
    assign result.fast_pwm      = fast_of(state_next.current_mode);
    assign result.green_on      = state_next.lamp_colors[0];
    assign result.red_on        = state_next.lamp_colors[1];
    assign result.blink_count   = blinks;
    assign result.blink_request = request;

endmodule

`default_nettype wire

/* verif/smc_tb_pkg.sv */
package smc_tb_pkg;
    import smc_pkg::*;

    localparam int MODES = 7;

    // drive level per mode, index 7 is dark
    localparam logic [7:0][7:0] DRIVE_LEVELS =
        {8'd0, 8'd255, 8'd125, 8'd40, 8'd12, 8'd3, 8'd1, 8'd0};
    // modes that use fast pwm
    localparam logic [7:0] FAST_MODES = 8'b0011_1000;

    class mode_tracker;
        cfg_t       knobs;
        logic [3:0] history;
        int         hold;
        int         on_ticks;
        int         top_run;
        int         low_run;
        logic [7:0] window [4];
        logic [2:0] mode;
        logic       armed;
        logic [1:0] lamps;
        result_t    outputs_due [$];
        int         error_count;

        function new();
            knobs       = CFG_RESET;
            history     = '0;
            hold        = 0;
            on_ticks    = 0;
            top_run     = 0;
            low_run     = 0;
            foreach (window[i])
                window[i] = VOLT_FOUR;
            mode        = '0;
            armed       = 1'b0;
            lamps       = '0;
            error_count = 0;
        endfunction

        task flag(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            error_count++;
        endtask

        function void set_knob(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_LONG_PRESS:    knobs.long_press_ticks   = value[6:0];
                REG_TOP_LIMIT:     knobs.top_limit          = value[15:0];
                REG_LOW_THRESH:    knobs.low_threshold      = value[7:0];
                REG_CRIT_THRESH:   knobs.critical_threshold = value[7:0];
                REG_LOWBATT_DELAY: knobs.lowbatt_delay      = value[7:0];
                REG_GREEN_THRESH:  knobs.green_threshold    = value[7:0];
                REG_YELLOW_THRESH: knobs.yellow_threshold   = value[7:0];
                REG_STEP_DIR:      knobs.short_steps_up     = value[0];
                default: ;
            endcase
        endfunction

        function void mode_up();
            int m;
            m = int'(mode) + 1;
            mode = (m >= MODES) ? 3'd0 : 3'(m);
        endfunction

        function void mode_down();
            if (mode == 3'd0)
                mode = 3'(MODES - 1);
            else
                mode = mode - 3'd1;
        endfunction

        // one tick of the controller, returns the outputs after the update
        function result_t next_outputs(item_t it);
            int         lp;
            int         avg;
            int         thr;
            logic [2:0] blinks;
            logic       request;
            result_t    r;
            lp      = (knobs.long_press_ticks < 2) ? 2 : int'(knobs.long_press_ticks);
            blinks  = '0;
            request = 1'b0;

            if (mode == 3'd0)
                on_ticks = 0;
            else if (on_ticks < 255)
                on_ticks++;

            history = {history[2:0], it.switch_down};

            if (history != 4'd0)
            begin
                // held: long steps at the first long period and then at every further one
                if (hold < 255)
                    hold++;
                if (hold == lp - 1 || hold == 2 * lp - 1)
                begin
                    if (knobs.short_steps_up)
                        mode_down();
                    else
                        mode_up();
                end
                if (hold == 2 * lp)
                    hold = lp;
                top_run = 0;
                low_run = 0;
            end
            else
            begin
                if (hold > 0 && hold < lp)
                begin
                    // short press released
                    if (knobs.short_steps_up)
                        mode_up();
                    else
                        mode_down();
                    if (on_ticks < 2 * lp)
                    begin
                        on_ticks = 1;
                        if (mode == 3'd0)
                            armed = 1'b1;
                    end
                end
                else
                begin
                    // turbo fall back
                    if (DRIVE_LEVELS[mode] == 8'd255)
                    begin
                        if (top_run < 65535)
                            top_run++;
                        if (top_run > int'(knobs.top_limit))
                            mode_down();
                    end
                    // battery average, lamps and readout
                    if (it.sample_ready)
                    begin
                        window[0] = window[1];
                        window[1] = window[2];
                        window[2] = window[3];
                        window[3] = it.battery_sample;
                        avg = (int'(window[0]) + int'(window[1]) + int'(window[2])
                               + int'(window[3])) >> 2;
                        thr = (mode == 3'd1) ? int'(knobs.critical_threshold)
                                             : int'(knobs.low_threshold);
                        if (avg < thr)
                        begin
                            if (low_run < 255)
                                low_run++;
                        end
                        else
                        begin
                            low_run = 0;
                        end
                        if (avg > int'(knobs.green_threshold))
                            lamps = 2'b01;
                        else if (avg > int'(knobs.yellow_threshold))
                            lamps = 2'b11;
                        else
                            lamps = 2'b10;
                        if (armed)
                        begin
                            if (avg >= int'(ADC_FULL_42))
                                blinks = 3'd5;
                            else if (avg > int'(VOLT_FOUR))
                                blinks = 3'd4;
                            else if (avg > int'(knobs.green_threshold))
                                blinks = 3'd3;
                            else if (avg > int'(knobs.yellow_threshold))
                                blinks = 3'd2;
                            else if (avg > int'(knobs.low_threshold))
                                blinks = 3'd1;
                            else
                                blinks = 3'd0;
                            request = 1'b1;
                            armed   = 1'b0;
                        end
                    end
                    // low battery step down
                    if (low_run >= int'(knobs.lowbatt_delay))
                    begin
                        mode_down();
                        low_run = 0;
                    end
                end
                hold = 0;
            end

            r.mode_number   = mode;
            r.drive_level   = DRIVE_LEVELS[mode];
            r.fast_pwm      = FAST_MODES[mode];
            r.green_on      = lamps[0];
            r.red_on        = lamps[1];
            r.blink_count   = blinks;
            r.blink_request = request;
            return r;
        endfunction

        function void take_tick(item_t it);
            outputs_due.push_back(next_outputs(it));
        endfunction

        task match_output(result_t got);
            result_t want;
            if (outputs_due.size() == 0)
            begin
                flag("result beat with no tick outstanding");
                return;
            end
            want = outputs_due.pop_front();
            if (got.mode_number !== want.mode_number)
                flag($sformatf("mode_number got %0d want %0d",
                               got.mode_number, want.mode_number));
            if (got.drive_level !== want.drive_level)
                flag($sformatf("drive_level got %0d want %0d",
                               got.drive_level, want.drive_level));
            if (got.fast_pwm !== want.fast_pwm)
                flag($sformatf("fast_pwm got %0d want %0d", got.fast_pwm, want.fast_pwm));
            if (got.green_on !== want.green_on)
                flag($sformatf("green_on got %0d want %0d", got.green_on, want.green_on));
            if (got.red_on !== want.red_on)
                flag($sformatf("red_on got %0d want %0d", got.red_on, want.red_on));
            if (got.blink_count !== want.blink_count)
                flag($sformatf("blink_count got %0d want %0d",
                               got.blink_count, want.blink_count));
            if (got.blink_request !== want.blink_request)
                flag($sformatf("blink_request got %0d want %0d",
                               got.blink_request, want.blink_request));
        endtask

        function int outstanding();
            return outputs_due.size();
        endfunction
    endclass

endpackage

/* verif/switch_mode_controller_top_test.sv */
module switch_mode_controller_top_test;
    import smc_pkg::*;
    import smc_tb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    smc_in_if  in_ch ();
    smc_out_if out_ch ();

    mode_tracker tracker;
    bit          src_idle;
    bit          sink_idle;
    int          volt_centre;
    int          stall_left;

    switch_mode_controller_top #(
        .MODE_COUNT (MODES)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side ready with random stall bursts
    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // tick beats accepted by the block
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            tracker.take_tick(item_t'{in_ch.switch_down, in_ch.sample_ready,
                                      in_ch.battery_sample});
    end

    // result beats leaving the block
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.match_output(result_t'{out_ch.mode_number, out_ch.drive_level,
                                           out_ch.fast_pwm, out_ch.green_on, out_ch.red_on,
                                           out_ch.blink_count, out_ch.blink_request});
    end

    // register write, setup then access phase
    task automatic write_knob(input logic [2:0] idx, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_knob(idx, value);
    endtask

    task automatic write_all(input int unsigned lp, input int unsigned top,
                             input int unsigned low, input int unsigned crit,
                             input int unsigned delay, input int unsigned green,
                             input int unsigned yellow, input int unsigned dir);
        write_knob(REG_LONG_PRESS, lp);
        write_knob(REG_TOP_LIMIT, top);
        write_knob(REG_LOW_THRESH, low);
        write_knob(REG_CRIT_THRESH, crit);
        write_knob(REG_LOWBATT_DELAY, delay);
        write_knob(REG_GREEN_THRESH, green);
        write_knob(REG_YELLOW_THRESH, yellow);
        write_knob(REG_STEP_DIR, dir);
    endtask

    // one tick beat, with an occasional gap before it
    task automatic send_tick(input logic sw, input logic rdy, input logic [7:0] batt);
        int gap;
        @(negedge clk);
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.switch_down    <= sw;
        in_ch.sample_ready   <= rdy;
        in_ch.battery_sample <= batt;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // battery reading around the current centre, sometimes anything
    function automatic logic [7:0] volt_sample();
        int v;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        v = volt_centre + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic release_tick();
        send_tick(1'b0, $urandom_range(0, 3) != 0, volt_sample());
    endtask

    // taps, long holds, quiet stretches and switch noise
    task automatic press_sequences(input int n);
        int sent;
        int lp;
        int kind;
        int k;
        int r;
        sent = 0;
        while (sent < n)
        begin
            lp   = (tracker.knobs.long_press_ticks < 2) ? 2 : tracker.knobs.long_press_ticks;
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 9) == 0)
                volt_centre = $urandom_range(0, 255);
            if (kind == 9)
            begin
                k = $urandom_range(1, 10);
                repeat (k) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     volt_sample());
                sent += k;
            end
            else
            begin
                if (kind <= 3)
                begin
                    // debounce stretches a press by three ticks
                    k = $urandom_range(1, (lp > 5) ? lp - 4 : 1);
                    r = $urandom_range(4, 10);
                end
                else if (kind <= 5)
                begin
                    k = $urandom_range((lp > 4) ? lp - 4 : 1, 2 * lp + 4);
                    r = $urandom_range(4, 20);
                end
                else
                begin
                    k = 0;
                    r = $urandom_range(5, 40);
                end
                repeat (k) send_tick(1'b1, 1'($urandom_range(0, 1)), 8'($urandom));
                repeat (r) release_tick();
                sent += k + r;
            end
        end
    endtask

    // battery extremes and two single taps, the first from off
    task automatic directed_ticks();
        repeat (4) send_tick(1'b0, 1'b1, 8'd255);
        repeat (4) send_tick(1'b0, 1'b1, 8'd0);
        send_tick(1'b0, 1'b0, 8'd255);
        send_tick(1'b0, 1'b1, ADC_FULL_42);
        send_tick(1'b0, 1'b1, VOLT_FOUR);
        repeat (2)
        begin
            send_tick(1'b1, 1'b0, 8'd0);
            repeat (4) send_tick(1'b0, 1'b1, 8'd200);
        end
    endtask

    // stop sending, drain all results, let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int i;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.switch_down    = 1'b0;
        in_ch.sample_ready   = 1'b0;
        in_ch.battery_sample = '0;
        src_idle             = 1'b1;
        sink_idle            = 1'b1;
        volt_centre          = 169;
        tracker              = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings
        directed_ticks();
        press_sequences(130);
        settle();

        // shortest long period, instant turbo drop, top thresholds, reversed steps
        write_all(2, 0, 255, 255, 1, 255, 255, 1);
        volt_centre = 240;
        press_sequences(150);
        settle();

        // longest long period, turbo never drops, bottom thresholds
        write_all(127, 65535, 0, 0, 255, 0, 0, 0);
        press_sequences(150);
        // leave the switch held so the next period starts below the count
        repeat (120) send_tick(1'b1, 1'b0, 8'($urandom));
        settle();

        // long period under the minimum, zero low battery delay
        write_all(1, 3, 150, 140, 0, 200, 180, 1);
        repeat (140) send_tick(1'b1, 1'b1, 8'($urandom));
        press_sequences(60);
        settle();

        // random settings, the last one without idling
        for (i = 0; i < 3; i++)
        begin
            if (i == 2)
            begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            write_all($urandom_range(2, 24), $urandom_range(0, 40), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(1, 6), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 1));
            volt_centre = $urandom_range(60, 220);
            press_sequences(130);
            settle();
        end

        if (tracker.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
